// ===== src/skr_pkg.sv =====
// Shared types and codes for the sparse Kaczmarz row update core.
package skr_pkg;

  localparam logic [1:0] KIND_LOAD = 2'd0;
  localparam logic [1:0] KIND_NZ   = 2'd1;
  localparam logic [1:0] KIND_READ = 2'd2;
  localparam logic [1:0] KIND_NONE = 2'd3;

  localparam logic [2:0] ST_OK        = 3'd0;
  localparam logic [2:0] ST_ZERO_NORM = 3'd1;
  localparam logic [2:0] ST_TOO_LONG  = 3'd2;
  localparam logic [2:0] ST_SAT       = 3'd3;
  localparam logic [2:0] ST_READ      = 3'd4;

  localparam logic CFG_RELAX   = 1'b0;
  localparam logic CFG_USE_RHS = 1'b1;

  localparam logic [47:0] QUOT_CAP  = 48'h7FFF_FFFF_FFFF;
  localparam logic [6:0]  DIV_STEPS = 7'd79;

  typedef struct packed {
    logic [1:0]         kind;
    logic [9:0]         column_index;
    logic signed [31:0] matrix_value;
    logic signed [31:0] rhs;
    logic               last_in_row;
  } skr_in_t;

  typedef struct packed {
    logic signed [31:0] read_value;
    logic [2:0]         status;
  } skr_out_t;

endpackage

// ===== src/skr_front.sv =====
// Front end: takes items, reduces the column index, drops unused kinds, queues the rest.
module skr_front #(
  parameter int VECTOR_LEN = 1024
) (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            in_valid_i,
  output logic            in_stall_o,
  input  skr_pkg::skr_in_t in_item_i,
  output logic            q_valid_o,
  input  logic            q_pop_i,
  output skr_pkg::skr_in_t q_item_o
);

  skr_pkg::skr_in_t mem_q [2];
  logic             wr_ptr_q, rd_ptr_q;
  logic [1:0]       cnt_q;
  skr_pkg::skr_in_t red_item;
  logic [30:0]      red_col;
  logic [30:0]      step_val;
  logic             push, pop;

  // Column modulo the vector length by restoring subtraction.
  always_comb begin
    red_col = 31'(in_item_i.column_index);
    for (int k = 9; k >= 0; k--) begin
      step_val = 31'(VECTOR_LEN) << k;
      if (red_col >= step_val) begin
        red_col = red_col - step_val;
      end
    end
    red_item = in_item_i;
    red_item.column_index = red_col[9:0];
  end

  assign in_stall_o = (cnt_q == 2'd2);
  assign push = in_valid_i && !in_stall_o && (in_item_i.kind != skr_pkg::KIND_NONE);
  assign pop  = q_pop_i && (cnt_q != 2'd0);
  assign q_valid_o = (cnt_q != 2'd0);
  assign q_item_o  = mem_q[rd_ptr_q];

  always_ff @(posedge clk_i) begin
    if (push) begin
      mem_q[wr_ptr_q] <= red_item;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= 1'b0;
      rd_ptr_q <= 1'b0;
      cnt_q    <= 2'd0;
    end else begin
      if (push) wr_ptr_q <= ~wr_ptr_q;
      if (pop) rd_ptr_q <= ~rd_ptr_q;
      cnt_q <= cnt_q + 2'(push) - 2'(pop);
    end
  end

endmodule

// ===== src/skr_back.sv =====
// Back end: x store, row store, accumulation, row-end division and update sequencer.
module skr_back #(
  parameter int VECTOR_LEN  = 1024,
  parameter int MAX_ROW_LEN = 64
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              q_valid_i,
  output logic              q_pop_o,
  input  skr_pkg::skr_in_t  q_item_i,
  input  logic [15:0]       relax_i,
  input  logic              use_rhs_i,
  input  logic              res_ready_i,
  output logic              res_valid_o,
  output skr_pkg::skr_out_t res_o
);

  localparam int XW = (VECTOR_LEN > 1) ? $clog2(VECTOR_LEN) : 1;
  localparam int RW = (MAX_ROW_LEN > 1) ? $clog2(MAX_ROW_LEN) : 1;
  localparam int CW = $clog2(MAX_ROW_LEN + 1);
  localparam logic [CW-1:0] MAX_CNT = CW'(MAX_ROW_LEN);

  typedef enum logic [3:0] {
    S_IDLE, S_READ, S_ACC1, S_ACC2, S_ACC3, S_FIN, S_DIV,
    S_SCALE, S_SCALE2, S_URROW, S_URX, S_UMUL, S_UWR, S_EMIT
  } state_e;

  state_e             state_q;
  skr_pkg::skr_in_t   cur_q;
  logic signed [31:0] x_mem [VECTOR_LEN];
  logic [9:0]         rc_mem [MAX_ROW_LEN];
  logic signed [31:0] rv_mem [MAX_ROW_LEN];
  logic signed [31:0] x_rdata_q;
  logic [9:0]         rcol_q;
  logic signed [31:0] rval_q;
  logic [63:0]        prod_q, dot_q, norm_q, rem_q, num_q, sprod_q, uprod_q;
  logic [47:0]        quo_q;
  logic [31:0]        m_q;
  logic [6:0]         step_q;
  logic [CW-1:0]      cnt_q, j_q;
  logic               ovf_q, sat_q;
  logic [2:0]         stat_q;

  logic               x_we;
  logic [XW-1:0]      x_wa, x_ra;
  logic signed [31:0] x_wd;
  logic               r_we;

  // Combinational helpers.
  logic [63:0] dot_base, dot_sum, dot_next;
  logic [64:0] norm_sum;
  logic [63:0] rem_sh, rem_sub;
  logic        rem_carry, take;
  logic [47:0] quo_next;
  logic [31:0] rmag;
  logic [47:0] delta;
  logic signed [49:0] nx;
  logic        upd_neg, nx_hi, nx_lo;

  always_comb begin
    if (cnt_q == '0 && !ovf_q) begin
      dot_base = use_rhs_i ? (64'd0 - ({{32{cur_q.rhs[31]}}, cur_q.rhs} << 16)) : 64'd0;
    end else begin
      dot_base = dot_q;
    end
    dot_sum = dot_base + prod_q;
    if (dot_base[63] == prod_q[63] && dot_sum[63] != dot_base[63]) begin
      dot_next = dot_base[63] ? 64'h8000_0000_0000_0000 : 64'h7FFF_FFFF_FFFF_FFFF;
    end else begin
      dot_next = dot_sum;
    end
    norm_sum  = {1'b0, norm_q} + {1'b0, prod_q};
    rem_carry = rem_q[63];
    rem_sh    = {rem_q[62:0], num_q[63]};
    take      = rem_carry || (rem_sh >= norm_q);
    rem_sub   = rem_sh - norm_q;
    quo_next  = {quo_q[46:0], take};
    rmag      = rval_q[31] ? (32'd0 - rval_q) : rval_q;
    delta     = uprod_q[63:16];
    upd_neg   = dot_q[63] ^ rval_q[31];
    nx = upd_neg ? (50'(x_rdata_q) + {2'b00, delta}) : (50'(x_rdata_q) - {2'b00, delta});
    nx_hi = (nx > 50'sh0_0000_7FFF_FFFF);
    nx_lo = (nx < -50'sh0_0000_8000_0000);
  end

  // Memory port control. A waiting read reply keeps reading its own entry.
  always_comb begin
    x_we = 1'b0;
    x_wa = XW'(q_item_i.column_index);
    x_wd = q_item_i.matrix_value;
    x_ra = (state_q == S_IDLE) ? XW'(q_item_i.column_index) :
           ((state_q == S_READ) ? XW'(cur_q.column_index) : XW'(rcol_q));
    r_we = 1'b0;
    unique case (state_q)
      S_IDLE: begin
        x_we = q_valid_i && (q_item_i.kind == skr_pkg::KIND_LOAD);
        r_we = q_valid_i && (q_item_i.kind == skr_pkg::KIND_NZ) && (cnt_q < MAX_CNT);
      end
      S_UWR: begin
        x_we = 1'b1;
        x_wa = XW'(rcol_q);
        x_wd = nx_hi ? 32'sh7FFF_FFFF : (nx_lo ? 32'sh8000_0000 : nx[31:0]);
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (x_we) x_mem[x_wa] <= x_wd;
    x_rdata_q <= x_mem[x_ra];
  end

  always_ff @(posedge clk_i) begin
    if (r_we) begin
      rc_mem[cnt_q[RW-1:0]] <= q_item_i.column_index;
      rv_mem[cnt_q[RW-1:0]] <= q_item_i.matrix_value;
    end
    rcol_q <= rc_mem[j_q[RW-1:0]];
    rval_q <= rv_mem[j_q[RW-1:0]];
  end

  assign q_pop_o     = (state_q == S_IDLE);
  assign res_valid_o = (state_q == S_READ) || (state_q == S_EMIT);
  always_comb begin
    res_o.read_value = (state_q == S_READ) ? x_rdata_q : 32'sd0;
    res_o.status     = (state_q == S_READ) ? skr_pkg::ST_READ : stat_q;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      dot_q   <= '0;
      norm_q  <= '0;
      cnt_q   <= '0;
      ovf_q   <= 1'b0;
      sat_q   <= 1'b0;
      stat_q  <= skr_pkg::ST_OK;
      j_q     <= '0;
      step_q  <= '0;
    end else begin
      unique case (state_q)
        S_IDLE: begin
          if (q_valid_i) begin
            cur_q <= q_item_i;
            unique case (q_item_i.kind)
              skr_pkg::KIND_READ: state_q <= S_READ;
              skr_pkg::KIND_NZ:   state_q <= S_ACC1;
              default:            state_q <= S_IDLE;
            endcase
          end
        end
        S_READ: begin
          if (res_ready_i) state_q <= S_IDLE;
        end
        S_ACC1: begin
          prod_q  <= 64'($signed(cur_q.matrix_value) * $signed(x_rdata_q));
          state_q <= S_ACC2;
        end
        S_ACC2: begin
          dot_q  <= dot_next;
          prod_q <= 64'($signed(cur_q.matrix_value) * $signed(cur_q.matrix_value));
          if (cnt_q < MAX_CNT) begin
            cnt_q <= cnt_q + CW'(1);
          end else begin
            ovf_q <= 1'b1;
          end
          state_q <= S_ACC3;
        end
        S_ACC3: begin
          norm_q  <= norm_sum[64] ? 64'hFFFF_FFFF_FFFF_FFFF : norm_sum[63:0];
          state_q <= cur_q.last_in_row ? S_FIN : S_IDLE;
        end
        S_FIN: begin
          sat_q  <= 1'b0;
          rem_q  <= '0;
          quo_q  <= '0;
          step_q <= '0;
          num_q  <= dot_q[63] ? (64'd0 - dot_q) : dot_q;
          if (ovf_q) begin
            stat_q  <= skr_pkg::ST_TOO_LONG;
            state_q <= S_EMIT;
          end else if (norm_q == '0) begin
            stat_q  <= skr_pkg::ST_ZERO_NORM;
            state_q <= S_EMIT;
          end else begin
            state_q <= S_DIV;
          end
        end
        S_DIV: begin
          num_q  <= {num_q[62:0], 1'b0};
          rem_q  <= take ? rem_sub : rem_sh;
          step_q <= step_q + 7'd1;
          if (quo_next > skr_pkg::QUOT_CAP) begin
            quo_q   <= skr_pkg::QUOT_CAP;
            sat_q   <= 1'b1;
            state_q <= S_SCALE;
          end else begin
            quo_q <= quo_next;
            if (step_q == skr_pkg::DIV_STEPS) state_q <= S_SCALE;
          end
        end
        S_SCALE: begin
          sprod_q <= 64'(quo_q * relax_i);
          state_q <= S_SCALE2;
        end
        S_SCALE2: begin
          if (sprod_q[63:46] != '0) begin
            m_q   <= 32'hFFFF_FFFF;
            sat_q <= 1'b1;
          end else begin
            m_q <= sprod_q[45:14];
          end
          j_q     <= '0;
          state_q <= S_URROW;
        end
        S_URROW: state_q <= S_URX;
        S_URX:   state_q <= S_UMUL;
        S_UMUL: begin
          uprod_q <= 64'(m_q * rmag);
          state_q <= S_UWR;
        end
        S_UWR: begin
          if (nx_hi || nx_lo) sat_q <= 1'b1;
          j_q <= j_q + CW'(1);
          if (j_q + CW'(1) == cnt_q) begin
            stat_q  <= (sat_q || nx_hi || nx_lo) ? skr_pkg::ST_SAT : skr_pkg::ST_OK;
            state_q <= S_EMIT;
          end else begin
            state_q <= S_URROW;
          end
        end
        S_EMIT: begin
          if (res_ready_i) begin
            dot_q   <= '0;
            norm_q  <= '0;
            cnt_q   <= '0;
            ovf_q   <= 1'b0;
            j_q     <= '0;
            state_q <= S_IDLE;
          end
        end
        default: state_q <= S_IDLE;
      endcase
    end
  end

`ifndef SYNTH
  a_cnt_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q <= MAX_CNT) else $error("row count beyond row store depth");
  a_ovf_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ovf_q |-> (cnt_q == MAX_CNT)) else $error("row overflow without a full row store");
  a_upd_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_UWR) |-> (j_q < cnt_q)) else $error("update index past stored row");
`endif

endmodule

// ===== src/sparse_kaczmarz_row_update_core.sv =====
// Top level of the sparse Kaczmarz row update core: front queue, back sequencer, output register.
//
// This core holds a Q16.16 solution vector x and projects it onto one sparse row at a time.
// Items load an x entry, read one back (one result item, status 4), or stream a row's
// nonzeros; the last nonzero of a row produces one result item with status ok, zero norm,
// row too long or saturated. In the back end a load is written from the idle state, a read
// waits in its own state until its result is taken, and each nonzero reads x, then forms
// its product and its square in turn in one product register. At a row's end the block
// checks the row, runs the bit-serial divider that forms dot/norm, scales by the relaxation
// factor, then per kept nonzero reads the row entry and x, multiplies and writes x back,
// and finally hands over the result. A two-entry queue in front lets
// items arrive while the back end is busy, and a result register lets the back end move
// on while a result waits.
// Configuration writes are taken at any time but belong to idle periods.
module sparse_kaczmarz_row_update_core #(
  parameter int VECTOR_LEN  = 1024,
  parameter int MAX_ROW_LEN = 64
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_stall_o,
  input  skr_pkg::skr_in_t  in_item_i,
  output logic              out_valid_o,
  input  logic              out_stall_i,
  output skr_pkg::skr_out_t out_item_o,
  input  logic              cfg_we_i,
  input  logic              cfg_index_i,
  input  logic [15:0]       cfg_data_i
);

  logic              q_valid, q_pop;
  skr_pkg::skr_in_t  q_item;
  logic              res_valid, res_ready;
  skr_pkg::skr_out_t res;
  logic [15:0]       relax_q;
  logic              use_rhs_q;
  logic              out_valid_q;
  skr_pkg::skr_out_t out_q;

  // Configuration registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      relax_q   <= 16'd16384;
      use_rhs_q <= 1'b1;
    end else if (cfg_we_i) begin
      unique case (cfg_index_i)
        skr_pkg::CFG_RELAX:   relax_q   <= cfg_data_i;
        skr_pkg::CFG_USE_RHS: use_rhs_q <= cfg_data_i[0];
        default: begin
        end
      endcase
    end
  end

  skr_front #(.VECTOR_LEN(VECTOR_LEN)) u_front (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .in_item_i  (in_item_i),
    .q_valid_o  (q_valid),
    .q_pop_i    (q_pop),
    .q_item_o   (q_item)
  );

  skr_back #(.VECTOR_LEN(VECTOR_LEN), .MAX_ROW_LEN(MAX_ROW_LEN)) u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .q_valid_i   (q_valid),
    .q_pop_o     (q_pop),
    .q_item_i    (q_item),
    .relax_i     (relax_q),
    .use_rhs_i   (use_rhs_q),
    .res_ready_i (res_ready),
    .res_valid_o (res_valid),
    .res_o       (res)
  );

  // The result register takes a new item whenever it is empty or being drained.
  assign res_ready = !out_valid_q || !out_stall_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (res_ready) begin
      out_valid_q <= res_valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (res_ready && res_valid) out_q <= res;
  end

  assign out_valid_o = out_valid_q;
  assign out_item_o  = out_q;

endmodule

// ===== tb/sparse_kaczmarz_row_update_core_tb.sv =====
// Self-checking regression bench for the sparse Kaczmarz row update core.
`timescale 1ns / 1ps

module sparse_kaczmarz_row_update_core_tb;

  localparam int VEC_LEN      = 1024;
  localparam int ROW_CAP      = 64;
  localparam int STALL_LIMIT  = 6000;
  localparam int SETTLE_CYCLES = 400;

  logic     clk;
  logic     rst_n;
  logic     in_valid;
  logic     in_stall;
  skr_pkg::skr_in_t  in_item;
  logic     out_valid;
  logic     out_stall;
  skr_pkg::skr_out_t out_item;
  logic     cfg_we;
  logic     cfg_index;
  logic [15:0] cfg_data;

  sparse_kaczmarz_row_update_core dut (
    .clk_i       (clk),
    .rst_ni      (rst_n),
    .in_valid_i  (in_valid),
    .in_stall_o  (in_stall),
    .in_item_i   (in_item),
    .out_valid_o (out_valid),
    .out_stall_i (out_stall),
    .out_item_o  (out_item),
    .cfg_we_i    (cfg_we),
    .cfg_index_i (cfg_index),
    .cfg_data_i  (cfg_data)
  );

  // Items waiting to be sent, and results that the predictor says must come back.
  skr_pkg::skr_in_t  pending_items[$];
  skr_pkg::skr_out_t expected_results[$];

  // Predictor copy of the block: solution vector, row buffers, accumulators, registers.
  logic signed [31:0] x_shadow[VEC_LEN];
  logic [9:0]         row_cols[ROW_CAP];
  logic signed [31:0] row_vals[ROW_CAP];
  logic [63:0]        dot_acc;
  logic [63:0]        norm_acc;
  int                 row_len;
  logic               row_too_long;
  logic [15:0]        omega;
  logic               rhs_on;

  // Generator bookkeeping: which x entries hold a loaded value.
  bit written[VEC_LEN];
  int written_cols[$];

  int  mismatches;
  int  failures;
  int  quiet_cycles;
  bit  no_idling;
  int  in_gap;
  int  out_gap;

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Finishes a row: returns too long or zero norm, else scales the correction and updates every kept entry of x.
  function automatic logic [2:0] project_row();
    logic [127:0] quot;
    logic [127:0] scale;
    logic [63:0]  dot_mag;
    logic [63:0]  val_mag;
    logic [63:0]  step;
    logic         dot_neg;
    logic         clipped;
    longint       next_x;
    clipped = 1'b0;
    if (row_too_long) return skr_pkg::ST_TOO_LONG;
    if (norm_acc == 64'd0) return skr_pkg::ST_ZERO_NORM;
    dot_neg = dot_acc[63];
    dot_mag = dot_neg ? -dot_acc : dot_acc;
    quot = ({64'd0, dot_mag} << 16) / {64'd0, norm_acc};
    if (quot > {80'd0, skr_pkg::QUOT_CAP}) begin
      quot = {80'd0, skr_pkg::QUOT_CAP};
      clipped = 1'b1;
    end
    scale = (quot * {112'd0, omega}) >> 14;
    if (scale > 128'hFFFF_FFFF) begin
      scale = 128'hFFFF_FFFF;
      clipped = 1'b1;
    end
    for (int j = 0; j < row_len; j++) begin
      val_mag = row_vals[j][31] ? -{{32{row_vals[j][31]}}, row_vals[j]}
                                : {32'd0, row_vals[j]};
      step = (scale[63:0] * val_mag) >> 16;
      next_x = longint'(x_shadow[row_cols[j]]);
      if (dot_neg != row_vals[j][31]) next_x = next_x + longint'(step);
      else next_x = next_x - longint'(step);
      if (next_x > 64'sh7FFF_FFFF) begin
        next_x = 64'sh7FFF_FFFF;
        clipped = 1'b1;
      end
      if (next_x < -64'sh8000_0000) begin
        next_x = -64'sh8000_0000;
        clipped = 1'b1;
      end
      x_shadow[row_cols[j]] = next_x[31:0];
    end
    return clipped ? skr_pkg::ST_SAT : skr_pkg::ST_OK;
  endfunction

  // Applies one accepted item to the predictor and queues any result it causes.
  task automatic predict_item(input skr_pkg::skr_in_t it);
    logic [63:0] prod;
    logic [63:0] sum;
    logic [63:0] sq;
    skr_pkg::skr_out_t res;
    case (it.kind)
      skr_pkg::KIND_LOAD: x_shadow[it.column_index] = it.matrix_value;
      skr_pkg::KIND_READ: begin
        res.read_value = x_shadow[it.column_index];
        res.status = skr_pkg::ST_READ;
        expected_results.push_back(res);
      end
      skr_pkg::KIND_NZ: begin
        // The right-hand side seeds the dot product on a row's first nonzero when enabled.
        if (row_len == 0 && !row_too_long)
          dot_acc = rhs_on ? -(64'(signed'(it.rhs)) <<< 16) : 64'd0;
        prod = 64'(signed'(it.matrix_value)) * 64'(signed'(x_shadow[it.column_index]));
        sum = dot_acc + prod;
        if (dot_acc[63] == prod[63] && sum[63] != dot_acc[63])
          sum = dot_acc[63] ? 64'h8000_0000_0000_0000 : 64'h7FFF_FFFF_FFFF_FFFF;
        dot_acc = sum;
        sq = 64'(signed'(it.matrix_value)) * 64'(signed'(it.matrix_value));
        sum = norm_acc + sq;
        norm_acc = (sum < sq) ? 64'hFFFF_FFFF_FFFF_FFFF : sum;
        if (row_len < ROW_CAP) begin
          row_cols[row_len] = it.column_index;
          row_vals[row_len] = it.matrix_value;
          row_len++;
        end else begin
          row_too_long = 1'b1;
        end
        if (it.last_in_row) begin
          res.read_value = '0;
          res.status = project_row();
          expected_results.push_back(res);
          dot_acc = '0;
          norm_acc = '0;
          row_len = 0;
          row_too_long = 1'b0;
        end
      end
      default: ;
    endcase
  endtask

  // Input driver: a new item is presented only once the previous one was taken.
  always @(posedge clk or negedge rst_n) begin
    if (!rst_n) begin
      in_valid <= 1'b0;
      in_item <= '0;
      in_gap <= 0;
    end else if (!in_valid || !in_stall) begin
      if (in_gap > 0) begin
        in_gap <= in_gap - 1;
        in_valid <= 1'b0;
      end else if (!no_idling && $urandom_range(0, 11) == 0) begin
        in_gap <= $urandom_range(0, 7);
        in_valid <= 1'b0;
      end else if (pending_items.size() != 0) begin
        in_item <= pending_items.pop_front();
        in_valid <= 1'b1;
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  // Output stall comes in bursts so that it hits every phase of the back end.
  always_ff @(posedge clk or negedge rst_n) begin
    if (!rst_n) begin
      out_stall <= 1'b0;
      out_gap <= 0;
    end else if (no_idling) begin
      out_stall <= 1'b0;
    end else if (out_gap > 0) begin
      out_gap <= out_gap - 1;
      out_stall <= 1'b1;
    end else if ($urandom_range(0, 9) == 0) begin
      out_gap <= $urandom_range(0, 7);
      out_stall <= 1'b1;
    end else begin
      out_stall <= 1'b0;
    end
  end

  // Monitor: predicts on every accepted input item and checks every accepted result.
  always @(posedge clk) begin
    skr_pkg::skr_out_t want;
    if (rst_n) begin
      if (in_valid && !in_stall) predict_item(in_item);
      if (out_valid && !out_stall) begin
        if (expected_results.size() == 0) begin
          failures++;
          if (mismatches < 10)
            $display("unexpected result: read_value %h status %0d",
                     out_item.read_value, out_item.status);
          mismatches++;
        end else begin
          want = expected_results.pop_front();
          if (want.read_value !== out_item.read_value || want.status !== out_item.status) begin
            failures++;
            if (mismatches < 10)
              $display("mismatch: expected read_value %h status %0d, got %h status %0d",
                       want.read_value, want.status, out_item.read_value, out_item.status);
            mismatches++;
          end
        end
      end
    end
  end

  // Watchdog: the run is stuck if nothing moves on either channel for too long.
  always @(posedge clk) begin
    if ((in_valid && !in_stall) || (out_valid && !out_stall)) quiet_cycles <= 0;
    else quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles >= STALL_LIMIT) begin
      $display("sparse_kaczmarz_row_update_core regression: fail");
      $finish;
    end
  end

  task automatic queue_item(input logic [1:0] kind, input int col, input logic [31:0] val,
                            input logic [31:0] rhs, input logic last);
    skr_pkg::skr_in_t it;
    it.kind = kind;
    it.column_index = col[9:0];
    it.matrix_value = val;
    it.rhs = rhs;
    it.last_in_row = last;
    if (kind == skr_pkg::KIND_LOAD && !written[col]) begin
      written[col] = 1'b1;
      written_cols.push_back(col);
    end
    pending_items.push_back(it);
  endtask

  // Mostly small Q16.16 magnitudes so that rows converge, sometimes full range.
  function automatic logic [31:0] pick_value();
    int r;
    r = $urandom_range(0, 99);
    if (r < 60) return $urandom_range(0, 32'h0004_0000) * ($urandom_range(0, 1) ? 1 : -1);
    if (r < 88) return $urandom_range(0, 32'h0100_0000) * ($urandom_range(0, 1) ? 1 : -1);
    return $urandom;
  endfunction

  function automatic int pick_written();
    return written_cols[$urandom_range(0, written_cols.size() - 1)];
  endfunction

  // Sends one row; loads and reads of x may fall between its nonzeros.
  task automatic queue_row(input int len, input bit zero_row, output int sent);
    sent = 0;
    for (int k = 0; k < len; k++) begin
      if ($urandom_range(0, 9) == 0) begin
        if ($urandom_range(0, 1)) queue_item(skr_pkg::KIND_LOAD, pick_written(), pick_value(),
                                             $urandom, $urandom_range(0, 1));
        else queue_item(skr_pkg::KIND_READ, pick_written(), $urandom, $urandom,
                        $urandom_range(0, 1));
        sent++;
      end
      queue_item(skr_pkg::KIND_NZ, pick_written(), zero_row ? 32'd0 : pick_value(),
                 pick_value(), k == len - 1);
      sent++;
    end
  endtask

  task automatic write_reg(input logic idx, input logic [15:0] data);
    @(posedge clk);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= data;
    @(posedge clk);
    cfg_we <= 1'b0;
    if (idx == skr_pkg::CFG_RELAX) omega = data;
    else rhs_on = data[0];
  endtask

  // Waits until every queued item was taken and every expected result arrived.
  task automatic drain();
    while (pending_items.size() != 0 || in_valid || expected_results.size() != 0)
      @(posedge clk);
    repeat (20) @(posedge clk);
  endtask

  initial begin
    logic [15:0] omega_set[6];
    logic        rhs_set[6];
    int count;
    int sent;
    int r;
    int len;
    mismatches = 0;
    failures = 0;
    quiet_cycles = 0;
    no_idling = 1'b0;
    cfg_we = 1'b0;
    cfg_index = skr_pkg::CFG_RELAX;
    cfg_data = '0;
    rst_n = 1'b0;
    omega = 16'd16384;
    rhs_on = 1'b1;
    dot_acc = '0;
    norm_acc = '0;
    row_len = 0;
    row_too_long = 1'b0;
    foreach (x_shadow[i]) x_shadow[i] = '0;
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;

    // Directed part: extreme entries and values, a plain row, a zero-norm row,
    // a saturating row, full-scale right-hand side, a read inside a row, kind three.
    queue_item(skr_pkg::KIND_LOAD, 0, 32'h7FFF_FFFF, 32'h0, 1'b0);
    queue_item(skr_pkg::KIND_LOAD, VEC_LEN - 1, 32'h8000_0000, 32'hFFFF_FFFF, 1'b1);
    queue_item(skr_pkg::KIND_READ, 0, 32'h0, 32'h0, 1'b0);
    queue_item(skr_pkg::KIND_READ, VEC_LEN - 1, 32'hFFFF_FFFF, 32'h0, 1'b1);
    queue_item(skr_pkg::KIND_LOAD, 0, 32'h0001_0000, 32'h0, 1'b0);
    queue_item(skr_pkg::KIND_LOAD, VEC_LEN - 1, 32'h0002_0000, 32'h0, 1'b0);
    queue_item(skr_pkg::KIND_LOAD, 5, 32'h0, 32'h0, 1'b0);
    queue_item(skr_pkg::KIND_NZ, 0, 32'h0001_0000, 32'h0003_0000, 1'b0);
    queue_item(skr_pkg::KIND_READ, VEC_LEN - 1, 32'h0, 32'h0, 1'b0);
    queue_item(skr_pkg::KIND_NZ, VEC_LEN - 1, 32'hFFFF_0000, 32'h0, 1'b1);
    queue_item(skr_pkg::KIND_NZ, 5, 32'h0, 32'h0, 1'b1);
    queue_item(skr_pkg::KIND_LOAD, 5, 32'h7FFF_0000, 32'h0, 1'b0);
    queue_item(skr_pkg::KIND_NZ, 5, 32'h0000_0001, 32'h8000_0000, 1'b1);
    queue_item(skr_pkg::KIND_NONE, 7, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 1'b1);
    queue_item(skr_pkg::KIND_NZ, 0, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 1'b1);
    queue_item(skr_pkg::KIND_NZ, 0, 32'h8000_0000, 32'h8000_0000, 1'b1);
    queue_item(skr_pkg::KIND_READ, 0, 32'h0, 32'h0, 1'b0);
    queue_item(skr_pkg::KIND_READ, 5, 32'h0, 32'h0, 1'b0);
    drain();

    // Register settings per phase, extremes included; the last phase runs without idling.
    omega_set = '{16'd16384, 16'd0, 16'd32768, 16'hFFFF, 16'd8192, 16'd16384};
    rhs_set = '{1'b1, 1'b1, 1'b0, 1'b1, 1'b0, 1'b1};
    for (int p = 0; p < 6; p++) begin
      write_reg(skr_pkg::CFG_RELAX,
                p == 5 ? 16'($urandom_range(12000, 20000)) : omega_set[p]);
      write_reg(skr_pkg::CFG_USE_RHS, {15'd0, rhs_set[p]});
      no_idling = (p == 5);
      count = 0;
      while (count < 240) begin
        r = $urandom_range(0, 99);
        if (r < 15) begin
          queue_item(skr_pkg::KIND_LOAD, $urandom_range(0, 3) == 0 ? pick_written()
                                                   : $urandom_range(0, VEC_LEN - 1),
                     pick_value(), $urandom, $urandom_range(0, 1));
          count++;
        end else if (r < 25) begin
          queue_item(skr_pkg::KIND_READ, pick_written(), $urandom, $urandom,
                     $urandom_range(0, 1));
          count++;
        end else if (r < 28) begin
          queue_item(skr_pkg::KIND_NONE, $urandom_range(0, VEC_LEN - 1), $urandom, $urandom,
                     $urandom_range(0, 1));
        end else begin
          r = $urandom_range(0, 99);
          if (r < 3) len = $urandom_range(ROW_CAP + 1, ROW_CAP + 4);
          else if (r < 6) len = $urandom_range(ROW_CAP - 3, ROW_CAP);
          else len = $urandom_range(1, 8);
          queue_row(len, $urandom_range(0, 29) == 0, sent);
          count += sent;
        end
      end
      drain();
    end

    while (pending_items.size() != 0 || in_valid || expected_results.size() != 0)
      @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
    failures += expected_results.size();
    if (failures == 0) begin
      $display("sparse_kaczmarz_row_update_core regression: pass");
    end else begin
      $display("sparse_kaczmarz_row_update_core regression: fail");
    end
    $finish;
  end

endmodule

// ===== filelist.f =====
src/skr_pkg.sv
src/skr_front.sv
src/skr_back.sv
src/sparse_kaczmarz_row_update_core.sv
tb/sparse_kaczmarz_row_update_core_tb.sv
